>>> hdl/tccs_pkg.sv
// Package: shared types and constants of the text console.
`default_nettype none

package tccs_pkg;

	localparam int CMD_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int ROW_PORT_W = 6;
	localparam int COL_PORT_W = 8;
	localparam int COLS_CFG_W = 9;
	localparam int ROWS_CFG_W = 7;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	localparam logic [MODE_W-1:0] MODE_SCROLL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BLANK  = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;

	localparam logic [COLS_CFG_W-1:0] COLS_RESET = 9'd80;
	localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd25;
	localparam logic [MODE_W-1:0]     MODE_RESET = MODE_SCROLL;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t               kind;
		logic [CHAR_W-1:0]      char_code;
		logic [ROW_PORT_W-1:0]  read_row;
		logic [COL_PORT_W-1:0]  read_column;
	} op_t;

	typedef struct packed {
		logic                   echo_valid;
		logic [CHAR_W-1:0]      echo_byte;
		logic [CHAR_W-1:0]      read_data;
		logic [ROW_PORT_W-1:0]  row_now;
		logic [COL_PORT_W-1:0]  column_now;
		logic                   scrolled;
	} res_t;

	typedef struct packed {
		logic [COLS_CFG_W-1:0] columns_in_use;
		logic [ROWS_CFG_W-1:0] rows_in_use;
		logic [MODE_W-1:0]     overflow_mode;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_RDATA
	} st_t;

endpackage

`default_nettype wire

>>> hdl/tccs_cmd_if.sv
// Interface: command channel of the text console.
`default_nettype none

interface tccs_cmd_if import tccs_pkg::*; ();

	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      command;
	logic [CHAR_W-1:0]     char_code;
	logic [ROW_PORT_W-1:0] read_row;
	logic [COL_PORT_W-1:0] read_column;

	modport source (output valid, command, char_code, read_row, read_column, input ready);
	modport sink (input valid, command, char_code, read_row, read_column, output ready);

endinterface

`default_nettype wire

>>> hdl/tccs_res_if.sv
// Interface: result channel of the text console.
`default_nettype none

interface tccs_res_if import tccs_pkg::*; ();

	logic                  valid;
	logic                  ready;
	logic                  echo_valid;
	logic [CHAR_W-1:0]     echo_byte;
	logic [CHAR_W-1:0]     read_data;
	logic [ROW_PORT_W-1:0] row_now;
	logic [COL_PORT_W-1:0] column_now;
	logic                  scrolled;

	modport source (output valid, echo_valid, echo_byte, read_data, row_now, column_now,
		scrolled, input ready);
	modport sink (input valid, echo_valid, echo_byte, read_data, row_now, column_now,
		scrolled, output ready);

endinterface

`default_nettype wire

>>> hdl/tccs_front.sv
// Front end: takes command items and classifies them into operations.
`default_nettype none

module tccs_front import tccs_pkg::*; (
	tccs_cmd_if.sink cmd,
	input  wire logic full,
	output op_t       push_data,
	output logic      push
);

	op_kind_t kind;

	always_comb begin
		unique case (cmd.command)
			CMD_PUT: begin
				if (cmd.char_code == CH_NEWLINE)
					kind = OP_NEWLINE;
				else if (cmd.char_code == CH_BACKSPACE)
					kind = OP_BACKSPACE;
				else
					kind = OP_PUT;
			end
			CMD_READ:  kind = OP_READ;
			CMD_CLEAR: kind = OP_CLEAR;
			default:   kind = OP_NOP;
		endcase
	end

	assign cmd.ready             = !full;
	assign push                  = cmd.valid && !full;
	assign push_data.kind        = kind;
	assign push_data.char_code   = cmd.char_code;
	assign push_data.read_row    = cmd.read_row;
	assign push_data.read_column = cmd.read_column;

endmodule

`default_nettype wire

>>> hdl/tccs_fifo.sv
// Queue: short operation queue between front and back end.
`default_nettype none

module tccs_fifo import tccs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  op_t       push_data,
	output logic      full,
	input  wire logic pop,
	output op_t       pop_data,
	output logic      not_empty
);

	op_t                    entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] ptr);
		if (ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
			return '0;
		return ptr + QUEUE_PTR_W'(1);
	endfunction

	assign full      = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + QUEUE_CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QUEUE_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

>>> hdl/tccs_back.sv
// Back end: cursor, ring offset, row flags, screen store and result register.
`default_nettype none

module tccs_back import tccs_pkg::*; #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  wire logic q_valid,
	input  op_t       q_data,
	output logic      pop,
	tccs_res_if.source res
);

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int SUM_W  = ROW_W + 1;
	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
	localparam int ADDR_W = $clog2(DEPTH);

	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
		input logic [ROW_W-1:0] top);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, lrow} + {1'b0, top};
		if (sum >= SUM_W'(MAX_ROWS))
			sum = sum - SUM_W'(MAX_ROWS);
		return sum[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
		input logic [COL_W-1:0] col);
		return ADDR_W'(prow) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col);
	endfunction

	// state
	st_t                   state_q, state_d;
	logic [ROW_PORT_W-1:0] cur_row_q, cur_row_d;
	logic [COL_PORT_W-1:0] cur_col_q, cur_col_d;
	logic [ROW_W-1:0]      top_q, top_d;
	logic [MAX_ROWS-1:0]   row_valid_q, row_valid_d;
	op_t                   op_q, op_d;
	logic [COL_W-1:0]      sweep_q, sweep_d;
	logic [ROW_W-1:0]      sweep_row_q, sweep_row_d;
	res_t                  out_q, out_d;
	logic                  out_valid_q, out_valid_d;

	// store
	logic [CHAR_W-1:0]     store_mem [DEPTH];
	logic [CHAR_W-1:0]     rd_data_q;
	logic                  mem_we;
	logic                  mem_re;
	logic [ADDR_W-1:0]     mem_addr;
	logic [CHAR_W-1:0]     mem_wdata;

	// derived values
	logic [COLS_CFG_W-1:0] eff_cols, cols_m1, col_inc;
	logic [ROWS_CFG_W-1:0] eff_rows, rows_m1, row_inc;
	logic                  mode_wr;
	logic                  cur_on;
	logic [ROW_W-1:0]      cur_phys;
	logic                  col_wrap;
	logic                  nl_ovf;
	logic [ROW_PORT_W-1:0] nl_row;
	logic [ROW_W-1:0]      top_inc;
	logic [ROW_W-1:0]      bottom_phys;
	logic [ROW_PORT_W-1:0] bs_row;
	logic [COL_PORT_W-1:0] bs_col;
	logic                  bs_on;
	logic [ROW_W-1:0]      bs_phys;
	logic                  rd_on;
	logic [ROW_W-1:0]      rd_phys;
	logic                  do_nl;
	logic                  echo;
	logic                  done;
	logic                  scrolled;
	logic [CHAR_W-1:0]     rdata_sel;

	assign eff_cols = (cfg.columns_in_use == '0) ? COLS_CFG_W'(1) :
		(cfg.columns_in_use > COLS_CFG_W'(MAX_COLUMNS)) ? COLS_CFG_W'(MAX_COLUMNS) :
		cfg.columns_in_use;
	assign eff_rows = (cfg.rows_in_use == '0) ? ROWS_CFG_W'(1) :
		(cfg.rows_in_use > ROWS_CFG_W'(MAX_ROWS)) ? ROWS_CFG_W'(MAX_ROWS) :
		cfg.rows_in_use;
	assign cols_m1  = eff_cols - COLS_CFG_W'(1);
	assign rows_m1  = eff_rows - ROWS_CFG_W'(1);
	assign mode_wr  = (cfg.overflow_mode == MODE_SCROLL) || (cfg.overflow_mode == MODE_BLANK);

	assign cur_on   = ({1'b0, cur_row_q} < eff_rows) && ({1'b0, cur_col_q} < eff_cols);
	assign cur_phys = phys_row(cur_row_q[ROW_W-1:0], top_q);
	assign col_inc  = {1'b0, cur_col_q} + COLS_CFG_W'(1);
	assign col_wrap = (col_inc >= eff_cols);

	assign row_inc     = {1'b0, cur_row_q} + ROWS_CFG_W'(1);
	assign nl_ovf      = (row_inc >= eff_rows);
	assign nl_row      = nl_ovf ? rows_m1[ROW_PORT_W-1:0] : row_inc[ROW_PORT_W-1:0];
	assign top_inc     = (top_q == ROW_W'(MAX_ROWS - 1)) ? '0 : top_q + ROW_W'(1);
	assign bottom_phys = phys_row(rows_m1[ROW_W-1:0], top_inc);

	always_comb begin
		bs_row = cur_row_q;
		bs_col = cur_col_q;
		if (cur_col_q != '0) begin
			bs_col = cur_col_q - COL_PORT_W'(1);
		end else if (cur_row_q != '0) begin
			bs_row = cur_row_q - ROW_PORT_W'(1);
			bs_col = cols_m1[COL_PORT_W-1:0];
		end
	end

	assign bs_on   = ({1'b0, bs_row} < eff_rows) && ({1'b0, bs_col} < eff_cols);
	assign bs_phys = phys_row(bs_row[ROW_W-1:0], top_q);

	assign rd_on   = ({1'b0, op_q.read_row} < eff_rows) &&
		({1'b0, op_q.read_column} < eff_cols);
	assign rd_phys = phys_row(op_q.read_row[ROW_W-1:0], top_q);

	always_comb begin
		state_d     = state_q;
		cur_row_d   = cur_row_q;
		cur_col_d   = cur_col_q;
		top_d       = top_q;
		row_valid_d = row_valid_q;
		op_d        = op_q;
		sweep_d     = sweep_q;
		sweep_row_d = sweep_row_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !res.ready;
		pop         = 1'b0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_addr    = '0;
		mem_wdata   = CH_SPACE;
		do_nl       = 1'b0;
		echo        = 1'b0;
		done        = 1'b0;
		scrolled    = 1'b0;
		rdata_sel   = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && (!out_valid_q || res.ready)) begin
					pop     = 1'b1;
					op_d    = q_data;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (op_q.kind)
					OP_PUT: begin
						if (mode_wr && cur_on && !row_valid_q[cur_phys]) begin
							// fresh row: blank it before the first character lands
							sweep_row_d = cur_phys;
							sweep_d     = '0;
							state_d     = ST_SWEEP;
						end else begin
							if (mode_wr && cur_on) begin
								mem_we    = 1'b1;
								mem_addr  = cell_addr(cur_phys, cur_col_q[COL_W-1:0]);
								mem_wdata = op_q.char_code;
							end
							if (col_wrap)
								do_nl = 1'b1;
							else
								cur_col_d = col_inc[COL_PORT_W-1:0];
							echo = 1'b1;
							done = 1'b1;
						end
					end
					OP_NEWLINE: begin
						do_nl = 1'b1;
						echo  = 1'b1;
						done  = 1'b1;
					end
					OP_BACKSPACE: begin
						cur_row_d = bs_row;
						cur_col_d = bs_col;
						// an unflagged row already reads as spaces
						if (mode_wr && bs_on && row_valid_q[bs_phys]) begin
							mem_we    = 1'b1;
							mem_addr  = cell_addr(bs_phys, bs_col[COL_W-1:0]);
							mem_wdata = CH_SPACE;
						end
						echo = 1'b1;
						done = 1'b1;
					end
					OP_READ: begin
						if (rd_on && row_valid_q[rd_phys]) begin
							mem_re   = 1'b1;
							mem_addr = cell_addr(rd_phys, op_q.read_column[COL_W-1:0]);
							state_d  = ST_RDATA;
						end else begin
							rdata_sel = CH_SPACE;
							done      = 1'b1;
						end
					end
					OP_CLEAR: begin
						row_valid_d = '0;
						top_d       = '0;
						cur_row_d   = '0;
						cur_col_d   = '0;
						done        = 1'b1;
					end
					default: begin
						done = 1'b1;
					end
				endcase

				if (do_nl) begin
					cur_col_d = '0;
					cur_row_d = nl_row;
					if (nl_ovf) begin
						if (cfg.overflow_mode == MODE_SCROLL) begin
							top_d                    = top_inc;
							row_valid_d[bottom_phys] = 1'b0;
							scrolled                 = 1'b1;
						end else if (cfg.overflow_mode == MODE_BLANK) begin
							top_d       = '0;
							row_valid_d = '0;
							scrolled    = 1'b1;
						end
					end
				end

				if (done) begin
					out_d.echo_valid = echo;
					out_d.echo_byte  = echo ? op_q.char_code : '0;
					out_d.read_data  = rdata_sel;
					out_d.row_now    = cur_row_d;
					out_d.column_now = cur_col_d;
					out_d.scrolled   = scrolled;
					out_valid_d      = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_addr  = cell_addr(sweep_row_q, sweep_q);
				mem_wdata = CH_SPACE;
				if (sweep_q == COL_W'(MAX_COLUMNS - 1)) begin
					row_valid_d[sweep_row_q] = 1'b1;
					state_d                  = ST_EXEC;
				end else begin
					sweep_d = sweep_q + COL_W'(1);
				end
			end
			ST_RDATA: begin
				out_d.echo_valid = 1'b0;
				out_d.echo_byte  = '0;
				out_d.read_data  = rd_data_q;
				out_d.row_now    = cur_row_q;
				out_d.column_now = cur_col_q;
				out_d.scrolled   = 1'b0;
				out_valid_d      = 1'b1;
				state_d          = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			top_q       <= '0;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cur_row_q   <= cur_row_d;
			cur_col_q   <= cur_col_d;
			top_q       <= top_d;
			row_valid_q <= row_valid_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q        <= op_d;
		sweep_q     <= sweep_d;
		sweep_row_q <= sweep_row_d;
		out_q       <= out_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			store_mem[mem_addr] <= mem_wdata;
		if (mem_re)
			rd_data_q <= store_mem[mem_addr];
	end

	assign res.valid      = out_valid_q;
	assign res.echo_valid = out_q.echo_valid;
	assign res.echo_byte  = out_q.echo_byte;
	assign res.read_data  = out_q.read_data;
	assign res.row_now    = out_q.row_now;
	assign res.column_now = out_q.column_now;
	assign res.scrolled   = out_q.scrolled;

endmodule

`default_nettype wire

>>> hdl/text_console_cursor_scroll.sv
// Top level: text console with cursor, wrapping and ring scrolling.
//
// Each command item gives one result item. Items pass through a two-entry
// queue to an executing back end that owns the cursor, the top-row ring offset
// and a single-port MAX_ROWS x MAX_COLUMNS character store. Puts, newlines,
// backspaces, clears, out-of-range reads and reads of a row still unflagged
// pass through ST_IDLE, which takes the item from the queue, and ST_EXEC,
// which executes it; a read of a flagged row adds ST_RDATA for the registered
// store read. Every store row carries a flag cleared at reset, on a clear and
// on overflow, so scrolling and blanking the store write no cells and no
// clearing pass runs after reset; an unflagged row reads as spaces. The first
// character put into an unflagged row first blanks that row, one cell a cycle,
// in ST_SWEEP. A result that waits on the output holds off the next item. The
// command side keeps accepting items while the queue has room.
`default_nettype none

module text_console_cursor_scroll import tccs_pkg::*; #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	tccs_cmd_if.sink                   cmd,
	tccs_res_if.source                 res
);

	cfg_t cfg_q;
	op_t  push_data;
	op_t  pop_data;
	logic push;
	logic full;
	logic pop;
	logic not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.columns_in_use <= COLS_RESET;
			cfg_q.rows_in_use    <= ROWS_RESET;
			cfg_q.overflow_mode  <= MODE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_COLUMNS: cfg_q.columns_in_use <= cfg_wdata[COLS_CFG_W-1:0];
				CFG_ROWS:    cfg_q.rows_in_use    <= cfg_wdata[ROWS_CFG_W-1:0];
				CFG_MODE:    cfg_q.overflow_mode  <= cfg_wdata[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tccs_front u_front (
		.cmd       (cmd),
		.full      (full),
		.push_data (push_data),
		.push      (push)
	);

	tccs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	tccs_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (not_empty),
		.q_data  (pop_data),
		.pop     (pop),
		.res     (res)
	);

endmodule

`default_nettype wire
